/* src/rsts_pkg.sv */
// Shared types and constants of the request slot table scheduler.
// Used by every module under src but rsts_ram; depends on nothing.
`default_nettype none

package rsts_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int CFG_DATA_W = 5;

	localparam logic [6:0] GRADE_CLEAN_MAX = 7'd70;
	localparam logic [6:0] GRADE_ERR_MAX = 7'd90;
	localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;
	localparam logic [4:0] SLOTS_RESET = 5'd15;

	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_INVITE = 2'd1;
	localparam logic [1:0] CLS_CODE = 2'd2;

	localparam logic CFG_SLOTS = 1'b0;
	localparam logic CFG_INTAKE = 1'b1;

	typedef enum logic [1:0] {
		OP_ARRIVE,
		OP_PICK,
		OP_FINISH,
		OP_RELEASE
	} op_t;

	typedef enum logic [1:0] {
		ST_WAITING,
		ST_SERVING,
		ST_DONE_OK,
		ST_DONE_FLAG
	} status_t;

	typedef enum logic [1:0] {
		GR_CLEAN,
		GR_ERRORS,
		GR_FLAGGED
	} grade_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SCAN,
		E_READ,
		E_COMMIT,
		E_OUT
	} eng_state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [1:0]  cls;
		status_t     status;
	} entry_t;

	// own_cls is CLS_NONE when the server takes any class
	typedef struct packed {
		op_t        op;
		logic [1:0] rcls;
		logic [1:0] own_cls;
		logic [3:0] tslot;
		logic       tslot_ok;
		grade_t     grade;
	} cmd_t;

	// packed so that done_ok lands in the lowest bit
	typedef struct packed {
		grade_t      grade_class;
		logic [31:0] request_id;
		logic [3:0]  chosen_slot;
		logic        done_ok;
	} res_t;

endpackage

`default_nettype wire

/* src/rsts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module rsts_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* src/rsts_front.sv */
// Intake side: decodes and classifies each input beat and holds it in a
// two-entry command queue for the engine. Depends on rsts_pkg.
`default_nettype none

module rsts_front #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [15:0]   in_tdata,
	input  logic [1:0]    in_tuser,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output rsts_pkg::cmd_t cmd
);
	import rsts_pkg::*;

	localparam int NSLOT = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;

	logic [1:0] rcls_in;
	logic [1:0] scls_in;
	logic [6:0] pct_in;
	cmd_t       cmd_in;
	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign rcls_in = in_tdata[1:0];
	assign scls_in = in_tdata[3:2];
	assign pct_in  = in_tdata[14:8];

	always_comb begin
		cmd_in.op       = op_t'(in_tuser);
		cmd_in.rcls     = (rcls_in == CLS_INVITE) ? CLS_INVITE : CLS_CODE;
		cmd_in.own_cls  = (scls_in == CLS_INVITE || scls_in == CLS_CODE) ? scls_in : CLS_NONE;
		cmd_in.tslot    = in_tdata[7:4];
		cmd_in.tslot_ok = ({1'b0, in_tdata[7:4]} < 5'(NSLOT));
		if (pct_in <= GRADE_CLEAN_MAX) begin
			cmd_in.grade = GR_CLEAN;
		end else if (pct_in <= GRADE_ERR_MAX) begin
			cmd_in.grade = GR_ERRORS;
		end else begin
			cmd_in.grade = GR_FLAGGED;
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/rsts_engine.sv */
// Execution side: scans the slot table one slot a cycle (arrive, pick) or reads the
// target slot, commits the operation, holds the result beat. Depends on rsts_pkg, rsts_ram.
`default_nettype none

module rsts_engine #(
	parameter int TABLE_DEPTH = 16,
	localparam int NSLOT = (TABLE_DEPTH < rsts_pkg::MAX_SLOTS) ? TABLE_DEPTH
		: rsts_pkg::MAX_SLOTS,
	localparam int CW = $clog2(NSLOT + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [CW-1:0]  usable,
	input  logic           intake_closed,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  rsts_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output rsts_pkg::res_t res
);
	import rsts_pkg::*;

	localparam int IW = $clog2(NSLOT);

	eng_state_t state_q, state_d;
	cmd_t       cmd_q;
	logic [CW-1:0] idx_q;
	logic       issue_s1;
	logic [IW-1:0] idx_s1;
	logic       vld_s1;
	logic [NSLOT-1:0] valid_q;
	logic [31:0] ctr_q;

	logic       free_found_q;
	logic [IW-1:0] free_slot_q;
	logic       own_found_q;
	logic [IW-1:0] own_slot_q;
	logic [31:0] own_id_q;
	logic [1:0] own_cls_q;
	logic       any_found_q;
	logic [IW-1:0] any_slot_q;
	logic [31:0] any_id_q;
	logic [1:0] any_cls_q;

	logic       wr_en;
	logic [IW-1:0] wr_addr;
	entry_t     wr_data;
	logic [IW-1:0] rd_addr;
	entry_t     rd_raw;
	entry_t     ent;
	logic       scan_more;
	logic       waiting;
	logic       take_free;
	logic       take_own;
	logic       take_any;
	logic       arrive_ok;
	logic       out_load;
	res_t       res_d;
	res_t       res_hold_q;
	res_t       res_q;

	rsts_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NSLOT)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign ent       = vld_s1 ? rd_raw : '0;
	assign scan_more = (idx_q < usable);
	assign waiting   = (ent.id != 32'd0) && (ent.status == ST_WAITING);
	assign take_free = (cmd_q.op == OP_ARRIVE) && !free_found_q && (ent.id == 32'd0);
	assign take_own  = (cmd_q.op == OP_PICK) && waiting && (cmd_q.own_cls != CLS_NONE)
		&& (ent.cls == cmd_q.own_cls) && (!own_found_q || ent.id < own_id_q);
	assign take_any  = (cmd_q.op == OP_PICK) && waiting
		&& (!any_found_q || ent.id < any_id_q);
	assign arrive_ok = free_found_q && !intake_closed && (ctr_q != ID_MAX);
	assign out_load  = (state_q == E_OUT) && (!res_valid || res_ready);
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		rd_addr = idx_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = cmd_q.tslot[IW-1:0];
		wr_data = '0;
		res_d   = '0;
		case (state_q)
			E_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_ARRIVE || cmd.op == OP_PICK) begin
						state_d = E_SCAN;
					end else begin
						state_d = E_READ;
					end
				end
			end
			E_SCAN: begin
				if (!scan_more && !issue_s1) begin
					state_d = E_COMMIT;
				end
			end
			E_READ: begin
				rd_addr = cmd_q.tslot[IW-1:0];
				state_d = E_COMMIT;
			end
			E_COMMIT: begin
				state_d = E_OUT;
				case (cmd_q.op)
					OP_ARRIVE: begin
						if (arrive_ok) begin
							wr_en             = 1'b1;
							wr_addr           = free_slot_q;
							wr_data.id        = ctr_q + 32'd1;
							wr_data.cls       = cmd_q.rcls;
							wr_data.status    = ST_WAITING;
							res_d.done_ok     = 1'b1;
							res_d.chosen_slot = 4'(free_slot_q);
							res_d.request_id  = ctr_q + 32'd1;
						end
					end
					OP_PICK: begin
						if (any_found_q) begin
							wr_en             = 1'b1;
							wr_addr           = own_found_q ? own_slot_q : any_slot_q;
							wr_data.id        = own_found_q ? own_id_q : any_id_q;
							wr_data.cls       = own_found_q ? own_cls_q : any_cls_q;
							wr_data.status    = ST_SERVING;
							res_d.done_ok     = 1'b1;
							res_d.chosen_slot = 4'(own_found_q ? own_slot_q : any_slot_q);
							res_d.request_id  = own_found_q ? own_id_q : any_id_q;
						end
					end
					OP_FINISH: begin
						wr_en             = cmd_q.tslot_ok && (ent.id != 32'd0);
						wr_data.id        = ent.id;
						wr_data.cls       = ent.cls;
						wr_data.status    = (cmd_q.grade == GR_FLAGGED) ? ST_DONE_FLAG
							: ST_DONE_OK;
						res_d.chosen_slot = cmd_q.tslot;
						res_d.request_id  = cmd_q.tslot_ok ? ent.id : 32'd0;
						res_d.grade_class = cmd_q.grade;
					end
					OP_RELEASE: begin
						wr_en             = cmd_q.tslot_ok;
						res_d.chosen_slot = cmd_q.tslot;
						res_d.request_id  = cmd_q.tslot_ok ? ent.id : 32'd0;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			E_OUT: begin
				if (out_load) begin
					state_d = E_IDLE;
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_IDLE;
			issue_s1  <= 1'b0;
			vld_s1    <= 1'b0;
			valid_q   <= '0;
			ctr_q     <= 32'd0;
			res_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= (state_q == E_SCAN) && scan_more;
			vld_s1   <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (state_q == E_COMMIT && cmd_q.op == OP_ARRIVE && arrive_ok) begin
				ctr_q <= ctr_q + 32'd1;
			end
			if (out_load) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// result waits in res_hold_q until the output beat is free
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
		if (state_q == E_COMMIT) begin
			res_hold_q <= res_d;
		end
		if (out_load) begin
			res_q <= res_hold_q;
		end
		if (state_q == E_IDLE) begin
			cmd_q        <= cmd;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			own_found_q  <= 1'b0;
			any_found_q  <= 1'b0;
		end else if (state_q == E_SCAN) begin
			if (scan_more) begin
				idx_q <= idx_q + CW'(1);
			end
			if (issue_s1) begin
				if (take_free) begin
					free_found_q <= 1'b1;
					free_slot_q  <= idx_s1;
				end
				if (take_own) begin
					own_found_q <= 1'b1;
					own_slot_q  <= idx_s1;
					own_id_q    <= ent.id;
					own_cls_q   <= ent.cls;
				end
				if (take_any) begin
					any_found_q <= 1'b1;
					any_slot_q  <= idx_s1;
					any_id_q    <= ent.id;
					any_cls_q   <= ent.cls;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_write_in_commit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == E_COMMIT)
		else $error("table written outside commit");

	a_issue_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1 |-> $past(state_q == E_SCAN))
		else $error("scan beat without scan state");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctr_q != $past(ctr_q)) |-> (ctr_q == $past(ctr_q) + 32'd1))
		else $error("id counter skipped");

	a_own_implies_any: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_COMMIT && cmd_q.op == OP_PICK && own_found_q) |-> any_found_q)
		else $error("own-class pick without any-class candidate");
`endif

endmodule

`default_nettype wire

/* src/request_slot_table_scheduler.sv */
// Request slot table scheduler, top level: configuration registers and the
// front/engine pair. Depends on rsts_pkg, rsts_front, rsts_engine, rsts_ram.
//
// Usage:
//   s_axis: one beat per operation; tuser = operation, tdata = request_class,
//   server_class, target_slot, grade_percent. m_axis: exactly one result beat
//   per operation, in order. cfg: register writes (index 0 slots_in_use,
//   index 1 intake_closed), always ready, to be written only while idle.
// Operation flow:
//   each s_axis beat is registered into the command queue. Finish and release
//   go from queue pop to result register through pop, read, commit and load;
//   arrive and pick scan N slots, N = min(slots_in_use, table slots), one
//   slot per cycle through the registered table read port, then drain the scan,
//   commit and load. The engine pops the next command once back in idle, so it
//   works on one operation at a time.
//   A two-beat command queue lets s_axis keep accepting while the engine works.
// Reset: table empty, id counter 0, slots_in_use 15, intake open.
// Stall: a held result beat blocks the engine; the queue fills, then
//   s_axis_tready drops.
`default_nettype none

module request_slot_table_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // request_class, server_class, target_slot, grade_percent
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // done_ok, chosen_slot, request_id, grade_class
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import rsts_pkg::*;

	localparam int NSLOT = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
	localparam int CW = $clog2(NSLOT + 1);

	logic [CFG_DATA_W-1:0] slots_in_use_q;
	logic                  intake_closed_q;
	logic [CW-1:0]         usable;
	logic                  cmd_valid;
	logic                  cmd_pop;
	cmd_t                  cmd;
	res_t                  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q  <= SLOTS_RESET;
			intake_closed_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SLOTS:  slots_in_use_q  <= cfg_data;
				CFG_INTAKE: intake_closed_q <= cfg_data[0];
				default:    intake_closed_q <= intake_closed_q;
			endcase
		end
	end

	assign usable = (slots_in_use_q >= CFG_DATA_W'(NSLOT)) ? CW'(NSLOT)
		: slots_in_use_q[CW-1:0];

	rsts_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	rsts_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.usable        (usable),
		.intake_closed (intake_closed_q),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res           (res)
	);

	assign m_axis_tdata = {1'b0, res};

endmodule

`default_nettype wire

/* tb/slot_table_checker.sv */
// Checker for the request slot table scheduler: follows the register writes and the
// operation beats, predicts each result beat and compares it with the block's output.
// Depends on rsts_pkg.
`default_nettype none

module slot_table_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // request_class, server_class, target_slot, grade_percent
	input  wire  [1:0]  s_axis_tuser,  // operation
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [39:0] m_axis_tdata,  // done_ok, chosen_slot, request_id, grade_class
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire         cfg_index,
	input  wire  [4:0]  cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import rsts_pkg::*;

	logic [31:0] slot_id [MAX_SLOTS];
	logic [1:0]  slot_cls [MAX_SLOTS];
	status_t     slot_st [MAX_SLOTS];
	logic [31:0] last_id;
	logic [4:0]  slots_cfg;
	logic        intake_shut;

	res_t result_q [$];
	res_t got;
	res_t want;

	initial begin
		mismatches = 0;
		outstanding = 0;
		checked = 0;
	end

	function automatic int live_slots();
		int n;
		n = slots_cfg;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		if (n > MAX_SLOTS) n = MAX_SLOTS;
		return n;
	endfunction

	// CLS_NONE matches either class
	function automatic int oldest_waiting(logic [1:0] cls);
		int n;
		int pos;
		n = live_slots();
		pos = -1;
		for (int i = 0; i < n; i++) begin
			if (slot_id[i] != '0 && slot_st[i] == ST_WAITING &&
					(cls == CLS_NONE || slot_cls[i] == cls) &&
					(pos < 0 || slot_id[i] < slot_id[pos]))
				pos = i;
		end
		return pos;
	endfunction

	function automatic res_t schedule(op_t op, logic [1:0] rcls, logic [1:0] scls,
			logic [3:0] tslot, logic [6:0] pct);
		res_t r;
		int n;
		int pos;
		grade_t g;
		r = '0;
		n = live_slots();
		pos = -1;
		case (op)
			OP_ARRIVE: begin
				for (int i = 0; i < n; i++)
					if (pos < 0 && slot_id[i] == '0) pos = i;
				if (pos >= 0 && !intake_shut && last_id != ID_MAX) begin
					last_id = last_id + 32'd1;
					slot_id[pos] = last_id;
					slot_cls[pos] = (rcls == CLS_INVITE) ? CLS_INVITE : CLS_CODE;
					slot_st[pos] = ST_WAITING;
					r.done_ok = 1'b1;
					r.chosen_slot = pos[3:0];
					r.request_id = last_id;
				end
			end
			OP_PICK: begin
				if (scls == CLS_INVITE || scls == CLS_CODE) pos = oldest_waiting(scls);
				if (pos < 0) pos = oldest_waiting(CLS_NONE);
				if (pos >= 0) begin
					slot_st[pos] = ST_SERVING;
					r.done_ok = 1'b1;
					r.chosen_slot = pos[3:0];
					r.request_id = slot_id[pos];
				end
			end
			OP_FINISH: begin
				if (pct <= GRADE_CLEAN_MAX) g = GR_CLEAN;
				else if (pct <= GRADE_ERR_MAX) g = GR_ERRORS;
				else g = GR_FLAGGED;
				r.grade_class = g;
				r.chosen_slot = tslot;
				if (tslot < TABLE_DEPTH) begin
					r.request_id = slot_id[tslot];
					if (slot_id[tslot] != '0)
						slot_st[tslot] = (g == GR_FLAGGED) ? ST_DONE_FLAG : ST_DONE_OK;
				end
			end
			default: begin
				r.chosen_slot = tslot;
				if (tslot < TABLE_DEPTH) begin
					r.request_id = slot_id[tslot];
					slot_id[tslot] = '0;
					slot_cls[tslot] = CLS_NONE;
					slot_st[tslot] = ST_WAITING;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_id[i] = '0;
				slot_cls[i] = CLS_NONE;
				slot_st[i] = ST_WAITING;
			end
			last_id = '0;
			slots_cfg = SLOTS_RESET;
			intake_shut = 1'b0;
			result_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SLOTS) slots_cfg = cfg_data;
				else intake_shut = cfg_data[0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[38:0]);
				if (result_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%t: result beat with nothing outstanding: ok=%0d slot=%0d id=%0d grade=%0d",
							$time, got.done_ok, got.chosen_slot, got.request_id, got.grade_class);
				end else begin
					want = result_q.pop_front();
					checked <= checked + 1;
					if (got.done_ok != want.done_ok || got.chosen_slot != want.chosen_slot ||
							got.request_id != want.request_id ||
							got.grade_class != want.grade_class) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("%t: beat %0d expected ok=%0d slot=%0d id=%0d grade=%0d, got ok=%0d slot=%0d id=%0d grade=%0d",
								$time, checked, want.done_ok, want.chosen_slot, want.request_id,
								want.grade_class, got.done_ok, got.chosen_slot, got.request_id,
								got.grade_class);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(schedule(op_t'(s_axis_tuser), s_axis_tdata[1:0],
					s_axis_tdata[3:2], s_axis_tdata[7:4], s_axis_tdata[14:8]));
			outstanding <= result_q.size();
		end
	end

endmodule

`default_nettype wire

/* tb/tb_request_slot_table_scheduler.sv */
// Top of the request slot table scheduler testbench: clock, reset, directed and random
// operation beats, register settings and random back-pressure; gives the verdict.
// Depends on rsts_pkg, request_slot_table_scheduler and slot_table_checker.
`default_nettype none

module tb_request_slot_table_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import rsts_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 75;
	localparam int CALM_PHASE = 6;
	localparam logic [1:0] CLS_ANY = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;

	int mismatches;
	int outstanding;
	int checked;
	bit calm = 1'b0;
	int n_arrive = 0;
	int n_pick = 0;
	int n_finish = 0;
	int n_release = 0;

	logic [4:0] slot_plan [PHASES] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd15, 5'd31, 5'd9, 5'd16};
	logic       shut_plan [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

	request_slot_table_scheduler #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	slot_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.checked(checked)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 13);
		end
	end

	initial begin
		#2ms;
		$display("request_slot_table_scheduler test failed");
		$finish;
	end

	task automatic send_op(op_t op, logic [1:0] rcls, logic [1:0] scls, logic [3:0] tslot,
			logic [6:0] pct);
		while (!calm && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {1'b0, pct, tslot, scls, rcls};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (op)
			OP_ARRIVE: n_arrive++;
			OP_PICK: n_pick++;
			OP_FINISH: n_finish++;
			default: n_release++;
		endcase
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// sender holds off until every outstanding result beat is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int span;
		int roll;
		int spins;
		op_t op;
		logic [1:0] rc;
		logic [3:0] ts;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, reset settings
		send_op(OP_RELEASE, CLS_INVITE, CLS_ANY, 4'd0, 7'd5);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd15, 7'd0);
		send_op(OP_PICK, CLS_INVITE, CLS_ANY, 4'd0, 7'd1);
		// odd request classes end up as code requests
		send_op(OP_ARRIVE, CLS_INVITE, CLS_ANY, 4'd0, 7'd1);
		send_op(OP_ARRIVE, CLS_CODE, CLS_ANY, 4'd0, 7'd1);
		send_op(OP_ARRIVE, CLS_NONE, CLS_ANY, 4'd0, 7'd1);
		send_op(OP_ARRIVE, CLS_ANY, CLS_ANY, 4'd0, 7'd1);
		send_op(OP_PICK, CLS_INVITE, CLS_CODE, 4'd0, 7'd1);
		send_op(OP_PICK, CLS_INVITE, CLS_INVITE, 4'd0, 7'd1);
		send_op(OP_PICK, CLS_INVITE, CLS_NONE, 4'd0, 7'd1);
		// no invitation left: falls back to any class
		send_op(OP_PICK, CLS_INVITE, CLS_INVITE, 4'd0, 7'd1);
		send_op(OP_PICK, CLS_INVITE, CLS_ANY, 4'd0, 7'd1);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd0, 7'd70);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd1, 7'd71);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd2, 7'd90);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd3, 7'd91);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd3, 7'd127);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd0, 7'd100);
		send_op(OP_RELEASE, CLS_INVITE, CLS_ANY, 4'd1, 7'd0);
		send_op(OP_ARRIVE, CLS_INVITE, CLS_ANY, 4'd15, 7'd127);
		send_op(OP_PICK, CLS_CODE, CLS_CODE, 4'd0, 7'd1);
		send_op(OP_FINISH, CLS_INVITE, CLS_ANY, 4'd15, 7'd50);
		send_op(OP_RELEASE, CLS_INVITE, CLS_ANY, 4'd15, 7'd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_SLOTS, slot_plan[ph]);
			write_reg(CFG_INTAKE, {4'($urandom_range(15)), shut_plan[ph]});
			cfg_valid <= 1'b0;
			@(posedge clk);
			calm = (ph == CALM_PHASE);
			span = (slot_plan[ph] == 0 || slot_plan[ph] > TABLE_DEPTH) ? TABLE_DEPTH :
				slot_plan[ph];
			for (int k = 0; k < PHASE_BEATS; k++) begin
				roll = $urandom_range(99);
				if (roll < 35) op = OP_ARRIVE;
				else if (roll < 65) op = OP_PICK;
				else if (roll < 80) op = OP_FINISH;
				else op = OP_RELEASE;
				rc = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(2, 1));
				ts = ($urandom_range(99) < 80) ? 4'($urandom_range(span - 1)) :
					4'($urandom_range(15));
				send_op(op, rc, 2'($urandom_range(3)), ts, 7'($urandom_range(127)));
			end
			drain();
			calm = 1'b0;
		end

		spins = 0;
		while (outstanding != 0 && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (50) @(posedge clk);

		$display("covered %0d arrives, %0d picks, %0d finishes, %0d releases", n_arrive,
			n_pick, n_finish, n_release);
		$display("%0d result beats checked over %0d register settings, stalls on and off",
			checked, PHASES + 1);
		if (mismatches == 0 && outstanding == 0) begin
			$display("request_slot_table_scheduler test passed");
		end else begin
			$display("request_slot_table_scheduler test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
